[hdl/dswc_pkg.sv]
`timescale 1ns / 1ps

package dswc_pkg;

    localparam int MAX_DICE   = 16;
    localparam int MAX_SUM    = 255;
    localparam int COUNT_BITS = 32;

    localparam int FACE_W   = 5;
    localparam int DICE_W   = 5;
    localparam int TARGET_W = 8;

    localparam int ENTRY_W = COUNT_BITS + 1;
    localparam int ACC_W   = ENTRY_W + FACE_W;
    localparam int ADDR_W  = $clog2(MAX_SUM + 1);
    localparam int STEP_W  = ADDR_W + 1;
    localparam int ROW_W   = $clog2(MAX_DICE + 1);

    localparam logic [FACE_W-1:0] FACE_RESET = FACE_W'(6);

    typedef logic [ENTRY_W-1:0] entry_t;
    typedef logic [ACC_W-1:0]   acc_t;

endpackage

[hdl/dice_sum_ways_counter.sv]
// Each query walks the table row by row: ST_RUN issues one window update per table entry up to the
//   target sum, ST_FLUSH closes the row, and ST_DONE hands the result to the output register.
// Zero dice or out-of-range queries go straight from ST_IDLE to ST_DONE.
// Throughput: one query at a time; s_ready is low until the query's result is registered.
// Reset (aresetn low, synchronous): control returns to idle, face_count returns to 6.
// No clearing pass: the first row is generated on the fly, later rows are written before read.
`timescale 1ns / 1ps

module dice_sum_ways_counter (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dswc_pkg::FACE_W-1:0]         cfg_face_count,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [dswc_pkg::DICE_W-1:0]         s_dice_count,
    input  logic [dswc_pkg::TARGET_W-1:0]       s_target_sum,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [dswc_pkg::COUNT_BITS-1:0]     m_way_count,
    output logic                                m_saturated
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam dswc_pkg::acc_t CAP = dswc_pkg::ACC_W'(1) << dswc_pkg::COUNT_BITS;

    logic [1:0]                      state_reg;
    logic [dswc_pkg::FACE_W-1:0]     faces_reg;
    logic [dswc_pkg::ROW_W-1:0]      dice_reg;
    logic [dswc_pkg::ADDR_W-1:0]     target_reg;
    logic [dswc_pkg::ROW_W-1:0]      row_reg;
    logic [dswc_pkg::STEP_W-1:0]     step_reg;
    logic                            cur_reg;
    logic                            first_reg;
    dswc_pkg::acc_t                  acc_reg;
    logic                            p_valid_reg;
    logic [dswc_pkg::ADDR_W-1:0]     p_addr_reg;
    logic                            p_va_reg;
    logic                            p_vb_reg;
    logic                            p_one_a_reg;
    logic                            p_one_b_reg;
    dswc_pkg::entry_t                rd_a0_reg;
    dswc_pkg::entry_t                rd_b0_reg;
    dswc_pkg::entry_t                rd_a1_reg;
    dswc_pkg::entry_t                rd_b1_reg;
    dswc_pkg::entry_t                res_reg;
    logic                            m_valid_reg;
    logic [dswc_pkg::COUNT_BITS-1:0] m_way_reg;
    logic                            m_sat_reg;

    dswc_pkg::entry_t mem0 [dswc_pkg::MAX_SUM+1];
    dswc_pkg::entry_t mem1 [dswc_pkg::MAX_SUM+1];

    logic [dswc_pkg::STEP_W-1:0] faces_ext;
    logic [dswc_pkg::STEP_W-1:0] idx_a;
    logic [dswc_pkg::STEP_W-1:0] idx_b;
    logic                        va;
    logic                        vb;
    logic [dswc_pkg::ADDR_W-1:0] addr_a;
    logic [dswc_pkg::ADDR_W-1:0] addr_b;
    dswc_pkg::entry_t            a_val;
    dswc_pkg::entry_t            b_val;
    dswc_pkg::acc_t              acc_sum;
    dswc_pkg::entry_t            wr_data;
    logic                        out_free;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);

    assign m_valid     = m_valid_reg;
    assign m_way_count = m_way_reg;
    assign m_saturated = m_sat_reg;

    // issue side: window enters at s-1 and leaves at s-1-faces
    assign faces_ext = dswc_pkg::STEP_W'(faces_reg);
    assign idx_a     = step_reg - dswc_pkg::STEP_W'(1);
    assign idx_b     = step_reg - faces_ext - dswc_pkg::STEP_W'(1);
    assign va        = (step_reg != '0);
    assign vb        = (step_reg > faces_ext);
    assign addr_a    = idx_a[dswc_pkg::ADDR_W-1:0];
    assign addr_b    = idx_b[dswc_pkg::ADDR_W-1:0];

    // execute side
    always_comb begin
        if (!p_va_reg) begin
            a_val = '0;
        end else if (first_reg) begin
            a_val = dswc_pkg::ENTRY_W'(p_one_a_reg);
        end else begin
            a_val = cur_reg ? rd_a1_reg : rd_a0_reg;
        end
        if (!p_vb_reg) begin
            b_val = '0;
        end else if (first_reg) begin
            b_val = dswc_pkg::ENTRY_W'(p_one_b_reg);
        end else begin
            b_val = cur_reg ? rd_b1_reg : rd_b0_reg;
        end
    end

    assign acc_sum = acc_reg + dswc_pkg::ACC_W'(a_val) - dswc_pkg::ACC_W'(b_val);
    assign wr_data = (acc_sum >= CAP) ? CAP[dswc_pkg::ENTRY_W-1:0]
                                      : acc_sum[dswc_pkg::ENTRY_W-1:0];
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (p_valid_reg && cur_reg) begin
            mem0[p_addr_reg] <= wr_data;
        end
        if (p_valid_reg && !cur_reg) begin
            mem1[p_addr_reg] <= wr_data;
        end
        rd_a0_reg <= mem0[addr_a];
        rd_b0_reg <= mem0[addr_b];
        rd_a1_reg <= mem1[addr_a];
        rd_b1_reg <= mem1[addr_b];
    end

    always_ff @(posedge aclk) begin
        p_addr_reg  <= step_reg[dswc_pkg::ADDR_W-1:0];
        p_va_reg    <= va;
        p_vb_reg    <= vb;
        p_one_a_reg <= (idx_a == '0);
        p_one_b_reg <= (idx_b == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            faces_reg   <= dswc_pkg::FACE_RESET;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            acc_reg     <= '0;
            row_reg     <= '0;
            step_reg    <= '0;
            cur_reg     <= 1'b0;
            first_reg   <= 1'b1;
        end else begin
            if (cfg_valid) begin
                faces_reg <= cfg_face_count;
            end
            p_valid_reg <= (state_reg == ST_RUN);
            if (p_valid_reg && state_reg == ST_RUN) begin
                acc_reg <= acc_sum;
            end
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        dice_reg   <= dswc_pkg::ROW_W'(s_dice_count);
                        target_reg <= dswc_pkg::ADDR_W'(s_target_sum);
                        row_reg    <= dswc_pkg::ROW_W'(1);
                        step_reg   <= '0;
                        cur_reg    <= 1'b0;
                        first_reg  <= 1'b1;
                        acc_reg    <= '0;
                        if (int'(s_dice_count) > dswc_pkg::MAX_DICE ||
                            int'(s_target_sum) > dswc_pkg::MAX_SUM) begin
                            res_reg   <= '0;
                            state_reg <= ST_DONE;
                        end else if (s_dice_count == '0) begin
                            res_reg   <= dswc_pkg::ENTRY_W'(s_target_sum == '0);
                            state_reg <= ST_DONE;
                        end else begin
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    step_reg <= step_reg + dswc_pkg::STEP_W'(1);
                    if (step_reg == dswc_pkg::STEP_W'(target_reg)) begin
                        state_reg <= ST_FLUSH;
                    end
                end
                ST_FLUSH: begin
                    acc_reg <= '0;
                    if (row_reg == dice_reg) begin
                        res_reg   <= wr_data;
                        state_reg <= ST_DONE;
                    end else begin
                        row_reg   <= row_reg + dswc_pkg::ROW_W'(1);
                        cur_reg   <= !cur_reg;
                        first_reg <= 1'b0;
                        step_reg  <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_sat_reg <= res_reg[dswc_pkg::COUNT_BITS];
            m_way_reg <= res_reg[dswc_pkg::COUNT_BITS] ? '1
                                                       : res_reg[dswc_pkg::COUNT_BITS-1:0];
        end
    end

endmodule

[hdl/dswc_checker.sv]
`timescale 1ns / 1ps

module dswc_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [dswc_pkg::COUNT_BITS-1:0]     m_way_count,
    input logic                                m_saturated
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_way_count) && $stable(m_saturated))
        else $error("result changed while stalled");

    // saturated count reads as all ones
    a_sat_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |-> m_way_count == '1)
        else $error("saturated flag without maximum count");

    // one query in flight: busy right after an input transaction
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while query in flight");

    // reset empties the result register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind dice_sum_ways_counter dswc_checker u_dswc_checker (.*);

[tb/sv/dice_sum_ways_counter_test.sv]
`timescale 1ns / 1ps

module dice_sum_ways_counter_test;

    typedef struct packed {
        logic [dswc_pkg::COUNT_BITS-1:0] way_count;
        logic                            saturated;
    } ways_result_t;

    localparam longint unsigned WAYS_CAP = 64'd1 << dswc_pkg::COUNT_BITS;

    logic                            aclk           = 1'b0;
    logic                            aresetn        = 1'b0;
    logic                            cfg_valid      = 1'b0;
    logic                            cfg_ready;
    logic [dswc_pkg::FACE_W-1:0]     cfg_face_count = '0;
    logic                            s_valid        = 1'b0;
    logic                            s_ready;
    logic [dswc_pkg::DICE_W-1:0]     s_dice_count   = '0;
    logic [dswc_pkg::TARGET_W-1:0]   s_target_sum   = '0;
    logic                            m_valid;
    logic                            m_ready        = 1'b0;
    logic [dswc_pkg::COUNT_BITS-1:0] m_way_count;
    logic                            m_saturated;

    ways_result_t                expected_ways[$];
    logic [dswc_pkg::FACE_W-1:0] face_setting  = dswc_pkg::FACE_RESET;
    int                          send_idle_pct = 0;
    int                          recv_idle_pct = 0;
    int                          err_count     = 0;
    int                          query_count   = 0;
    int                          result_count  = 0;
    int                          cfg_writes    = 0;

    dice_sum_ways_counter DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_face_count (cfg_face_count),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_dice_count   (s_dice_count),
        .s_target_sum   (s_target_sum),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_way_count    (m_way_count),
        .m_saturated    (m_saturated)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Row-by-row window sums, entries capped at 2^COUNT_BITS.
    function automatic ways_result_t count_ways(
            input logic [dswc_pkg::DICE_W-1:0]   dice,
            input logic [dswc_pkg::TARGET_W-1:0] target,
            input logic [dswc_pkg::FACE_W-1:0]   faces);
        longint unsigned prev_row [0:dswc_pkg::MAX_SUM];
        longint unsigned next_row [0:dswc_pkg::MAX_SUM];
        longint unsigned acc;
        ways_result_t    res;
        res = '0;
        if (int'(dice) > dswc_pkg::MAX_DICE || int'(target) > dswc_pkg::MAX_SUM) begin
            return res;
        end
        for (int s = 0; s <= dswc_pkg::MAX_SUM; s++) begin
            prev_row[s] = 0;
            next_row[s] = 0;
        end
        prev_row[0] = 1;
        for (int d = 1; d <= int'(dice); d++) begin
            for (int s = 0; s <= int'(target); s++) begin
                acc = 0;
                for (int i = 1; i <= int'(faces) && i <= s; i++) begin
                    acc = (acc + prev_row[s-i] >= WAYS_CAP) ? WAYS_CAP : acc + prev_row[s-i];
                end
                next_row[s] = acc;
            end
            prev_row = next_row;
        end
        if (prev_row[target] >= WAYS_CAP) begin
            res.way_count = '1;
            res.saturated = 1'b1;
        end else begin
            res.way_count = prev_row[target][dswc_pkg::COUNT_BITS-1:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Result checker and receiver-side stall generator.
    always @(posedge aclk) begin
        ways_result_t want;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (expected_ways.size() == 0) begin
                report_mismatch($sformatf("unexpected result transaction: ways=%0d sat=%0b",
                                          m_way_count, m_saturated));
            end else begin
                want = expected_ways.pop_front();
                if (m_way_count !== want.way_count)
                    report_mismatch($sformatf("way_count %0d, expected %0d",
                                              m_way_count, want.way_count));
                if (m_saturated !== want.saturated)
                    report_mismatch($sformatf("saturated %0b, expected %0b",
                                              m_saturated, want.saturated));
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_query(input logic [dswc_pkg::DICE_W-1:0]   dice,
                              input logic [dswc_pkg::TARGET_W-1:0] target);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_dice_count <= dice;
        s_target_sum <= target;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_ways.push_back(count_ways(dice, target, face_setting));
        query_count++;
    endtask

    task automatic drain_queries();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_ways.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_faces(input logic [dswc_pkg::FACE_W-1:0] faces);
        drain_queries();
        cfg_valid      <= 1'b1;
        cfg_face_count <= faces;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid    <= 1'b0;
        face_setting = faces;
        cfg_writes++;
    endtask

    // Reset face count: zero dice, reach limits, saturation, too many dice.
    task automatic test_default_faces();
        send_query(0, 0);
        send_query(0, 5);
        send_query(1, 0);
        send_query(1, 6);
        send_query(1, 7);
        send_query(2, 7);
        send_query(3, 10);
        send_query(16, 96);
        send_query(16, 97);
        send_query(16, 56);
        send_query(17, 3);
        send_query(31, 255);
    endtask

    task automatic test_face_extremes();
        write_faces(0);
        send_query(0, 0);
        send_query(2, 0);
        send_query(3, 3);
        write_faces(1);
        send_query(16, 16);
        send_query(16, 15);
        write_faces(31);
        send_query(1, 31);
        send_query(2, 62);
        send_query(16, 255);
        write_faces(16);
        send_query(16, 136);
        send_query(5, 4);
    endtask

    // Mostly small in-reach queries, some full-size ones, some raw noise.
    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n);
        int dice;
        int target;
        int reach;
        int pick;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int g = 0; g < 4; g++) begin
            if ($urandom_range(9) == 0)
                write_faces(dswc_pkg::FACE_W'($urandom_range(31)));
            else
                write_faces(dswc_pkg::FACE_W'($urandom_range(16, 1)));
            for (int k = 0; k < n / 4; k++) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    dice   = $urandom_range(5);
                    reach  = dice * int'(face_setting) + 2;
                    target = $urandom_range(reach > dswc_pkg::MAX_SUM ? dswc_pkg::MAX_SUM
                                                                      : reach);
                end else if (pick < 85) begin
                    dice   = $urandom_range(dswc_pkg::MAX_DICE);
                    reach  = dice * int'(face_setting) + 4;
                    target = $urandom_range(reach > dswc_pkg::MAX_SUM ? dswc_pkg::MAX_SUM
                                                                      : reach);
                end else if (pick < 92) begin
                    dice   = $urandom_range(dswc_pkg::MAX_DICE, 12);
                    target = $urandom_range(dswc_pkg::MAX_SUM, 128);
                end else begin
                    dice   = $urandom_range(31);
                    target = $urandom_range(255);
                end
                send_query(dswc_pkg::DICE_W'(dice), dswc_pkg::TARGET_W'(target));
            end
        end
    endtask

    initial begin
        send_idle_pct = 12;
        recv_idle_pct = 66;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_faces();
        test_face_extremes();
        test_random_traffic(12, 66, 40);
        test_random_traffic(66, 12, 40);
        test_random_traffic(0, 0, 40);
        drain_queries();
        repeat (20) @(posedge aclk);
        $display("Sent %0d queries, checked %0d results over %0d face count writes.",
                 query_count, result_count, cfg_writes);
        $display("Covered corner queries, saturation, and three stall profiles.");
        if (err_count == 0 && expected_ways.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timeout with %0d results outstanding", expected_ways.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
